### src/dfd_pkg.sv
// shared types, codes and helpers for the device flap detector table
// no dependencies; imported by dfd_cell and device_flap_detector_table
package dfd_pkg;

    localparam int TABLE_ENTRIES_DEFAULT = 16;

    localparam logic [15:0] WINDOW_RESET = 16'd400;

    localparam logic [1:0] OP_ATTACH = 2'd0;
    localparam logic [1:0] OP_DETACH = 2'd1;

    localparam logic [1:0] REPORT_NONE   = 2'd0;
    localparam logic [1:0] REPORT_ATTACH = 2'd1;
    localparam logic [1:0] REPORT_DETACH = 2'd2;
    localparam logic [1:0] REPORT_FAULT  = 2'd3;

    // values held still for the whole walk of one beat
    typedef struct packed {
        logic        is_event;
        logic        attach;
        logic [31:0] key;
        logic [31:0] now;
        logic [15:0] window;
    } dfd_bcast_t;

    // token handed from cell to cell
    typedef struct packed {
        logic       valid;
        logic       found;
        logic       placed;
        logic [1:0] report;
    } dfd_token_t;

    function automatic logic [1:0] report_notice(input logic attach);
        report_notice = attach ? REPORT_ATTACH : REPORT_DETACH;
    endfunction

endpackage

### src/dfd_cell.sv
// one table entry of the flap detector chain: key, time, status, valid
// depends on dfd_pkg for the broadcast and token types
module dfd_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  dfd_pkg::dfd_bcast_t bcast,
    input  dfd_pkg::dfd_token_t tok_in,
    output dfd_pkg::dfd_token_t tok_out,
    output logic              hit
);
    import dfd_pkg::*;

    logic        valid_reg, valid_next;
    logic [31:0] key_reg, key_next;
    logic [31:0] time_reg, time_next;
    logic        attached_reg, attached_next;
    dfd_token_t  tok_reg, tok_next;
    logic [31:0] age;
    logic        in_window;

    assign hit       = valid_reg && (key_reg == bcast.key);
    assign age       = bcast.now - time_reg;
    assign in_window = age <= {16'd0, bcast.window};
    assign tok_out   = tok_reg;

    always_comb begin
        valid_next    = valid_reg;
        key_next      = key_reg;
        time_next     = time_reg;
        attached_next = attached_reg;
        tok_next      = tok_in;
        if (tok_in.valid) begin
            if (bcast.is_event && hit) begin
                // known key: report on a status change, then refresh
                if (attached_reg != bcast.attach) begin
                    tok_next.report = in_window ? REPORT_FAULT : report_notice(bcast.attach);
                end
                time_next     = bcast.now;
                attached_next = bcast.attach;
            end else if (bcast.is_event && !tok_in.found && !tok_in.placed && !valid_reg) begin
                // first free entry takes the new key
                valid_next      = 1'b1;
                key_next        = bcast.key;
                time_next       = bcast.now;
                attached_next   = bcast.attach;
                tok_next.placed = 1'b1;
            end else if (valid_reg && !in_window) begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            tok_reg.valid <= tok_next.valid;
        end
        key_reg        <= key_next;
        time_reg       <= time_next;
        attached_reg   <= attached_next;
        tok_reg.found  <= tok_next.found;
        tok_reg.placed <= tok_next.placed;
        tok_reg.report <= tok_next.report;
    end

endmodule

### src/device_flap_detector_table.sv
// top level of the device flap detector table: stream ports, apb register,
// sequencer and the chain of dfd_cell entries; depends on dfd_pkg and dfd_cell
//
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  op, device_key, now_ms
// m_        out  m_tvalid/m_tready  report, dropped
// apb       in   psel/penable       window_ms at byte address 0
//
// s_tready drops once a beat is taken and stays low through the match, walk and
// done states, so a new beat is taken only after the last result is handed on:
// the match state, where every cell compares its key with the beat's key at once and
// the token enters the head cell, then the token passes through every cell register
// until it leaves the tail cell, then the result is registered in the done state and
// handed to the output register; m_tvalid rises once the output register is free
// reset (synchronous, aresetn low) clears all valid bits, window_ms becomes 400
// a result waiting on m_tready does not block acceptance; only a second finished
// result waits in the done state until the output register frees up
module device_flap_detector_table #(
    parameter int TABLE_ENTRIES = dfd_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // op[1:0], device_key[33:2], now_ms[65:34], zero pad
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // report[1:0], dropped[2], zero pad
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dfd_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MATCH = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [15:0] window_reg;
    logic [1:0]  op_reg;
    logic [31:0] key_reg;
    logic [31:0] now_reg;
    logic [1:0]  res_report_reg, res_report_next;
    logic        res_dropped_reg, res_dropped_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [1:0]  m_report_reg, m_report_next;
    logic        m_dropped_reg, m_dropped_next;

    dfd_bcast_t                bcast;
    dfd_token_t                chain [0:TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]  hits;
    logic                      found;
    logic                      s_accept;
    logic                      out_free;

    // apb: always ready, only the register at index zero exists
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, window_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            window_reg <= pwdata[15:0];
        end
    end

    // stream side handshakes
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_dropped_reg, m_report_reg};

    // beat fields held in registers for the whole walk
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg  <= s_tdata[1:0];
            key_reg <= s_tdata[33:2];
            now_reg <= s_tdata[65:34];
        end
    end

    assign bcast.is_event = (op_reg == OP_ATTACH) || (op_reg == OP_DETACH);
    assign bcast.attach   = (op_reg == OP_ATTACH);
    assign bcast.key      = key_reg;
    assign bcast.now      = now_reg;
    assign bcast.window   = window_reg;

    // keys are unique among valid entries, so an or of the compares is the lookup
    assign found = |hits;

    // token injection into the head of the chain during the match cycle
    always_comb begin
        chain[0].valid  = (state_reg == ST_MATCH);
        chain[0].found  = found;
        chain[0].placed = 1'b0;
        chain[0].report = (bcast.is_event && !found) ? report_notice(bcast.attach)
                                                     : REPORT_NONE;
    end

    // the row of entries
    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        dfd_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .bcast   (bcast),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1]),
            .hit     (hits[i])
        );
    end

    // sequencer
    always_comb begin
        state_next       = state_reg;
        res_report_next  = res_report_reg;
        res_dropped_next = res_dropped_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_report_next    = m_report_reg;
        m_dropped_next   = m_dropped_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: begin
                state_next = ST_WALK;
            end
            ST_WALK: begin
                // token has left the tail cell
                if (chain[TABLE_ENTRIES].valid) begin
                    res_report_next  = chain[TABLE_ENTRIES].report;
                    res_dropped_next = bcast.is_event && !chain[TABLE_ENTRIES].found
                                       && !chain[TABLE_ENTRIES].placed;
                    state_next       = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    m_report_next  = res_report_reg;
                    m_dropped_next = res_dropped_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        res_report_reg  <= res_report_next;
        res_dropped_reg <= res_dropped_next;
        m_report_reg    <= m_report_next;
        m_dropped_reg   <= m_dropped_next;
    end

endmodule
